FILE: hdl/bsr_diagonal_scale_axpby_defines.svh
// Assertion macros shared by the diagonal-scale axpby RTL.
`ifndef BSR_DIAGONAL_SCALE_AXPBY_DEFINES_SVH
`define BSR_DIAGONAL_SCALE_AXPBY_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hdl/bdsa_pkg.sv
// Shared constants, types and saturation helper for the diagonal-scale axpby block.
package bdsa_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_BLOCK = 16;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int BS_W      = $clog2(MAX_BLOCK + 1);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] REG_ALPHA      = 2'd0;
  localparam logic [1:0] REG_BETA       = 2'd1;
  localparam logic [1:0] REG_BLK_DIM    = 2'd2;
  localparam logic [1:0] REG_BLOCK_ROWS = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } qsat_t;

  // Clips a wide signed value to the 32-bit signed range and flags clipping.
  function automatic qsat_t sat_q32(input logic signed [63:0] v);
    qsat_t r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end else begin
      r.val = v[63] ? Q_MIN : Q_MAX;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/bsr_diagonal_scale_axpby.sv
// Top level of the diagonal-scale axpby block over a block-sparse diagonal store.
`include "bsr_diagonal_scale_axpby_defines.svh"

// The block holds one diagonal entry per scalar row and works on one command at a
// time. After reset it sweeps the 1024-entry store to zero, one entry per cycle, and
// holds busy high for the whole sweep; configuration writes are taken meanwhile.
// A command is taken at a rising edge with start high and busy low. Load and clear
// commands give no result. A compute command gives exactly one result: done is high
// for a single cycle, with y_out and overflow valid alongside it. The receiver cannot
// hold the result off, so it must capture the word in that cycle. The work is done
// by the single shared two-stage Q16.16 multiplier, which forms alpha times the
// diagonal, then beta times y, then that first product times x, followed by one
// saturating add. The configuration channel is always ready; registers must only
// be written while the block is idle.
module bsr_diagonal_scale_axpby
  import bdsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [9:0]         block_row,
  input  logic [9:0]         block_col,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [31:0] elem_value,
  input  logic [9:0]         row,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  // Result channel.
  output logic               done,
  output logic signed [31:0] y_out,
  output logic               overflow,
  // Configuration channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_M1    = 8'b0000_1000,
    S_M1W   = 8'b0001_0000,
    S_M2    = 8'b0010_0000,
    S_M2W   = 8'b0100_0000,
    S_ADD   = 8'b1000_0000
  } state_t;

  localparam int NF_W  = 11 + BS_W;
  localparam int IDX_W = 10 + BS_W + 1;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic signed [31:0] alpha_gain;
  logic signed [31:0] beta_gain;
  logic [4:0]         blk_dim;
  logic [10:0]        block_rows;

  // The command that is being worked on.
  logic [1:0]         op_q;
  logic [9:0]         brow_q;
  logic [9:0]         bcol_q;
  logic [3:0]         irow_q;
  logic [3:0]         icol_q;
  logic signed [31:0] elem_q;
  logic [9:0]         row_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;

  // Diagonal store with one write port and one registered read port.
  logic signed [31:0] diag_mem [MAX_ROWS];
  logic signed [31:0] rd_data;
  logic               wr_en;
  logic [ROW_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;
  logic [ROW_W-1:0]   clr_cnt;

  // Geometry derived from the configuration.
  logic [BS_W-1:0]    bs;
  logic [NF_W-1:0]    n_full;
  logic [ROW_W:0]     n_rows;
  logic [IDX_W-1:0]   idx_full;
  logic               load_ok;
  logic               row_ok;
  logic               in_range;

  // Shared multiplier and the datapath around it.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_q;
  logic               mul_ovf;
  logic signed [31:0] t1;
  logic               ovf_acc;
  logic signed [63:0] sum_wide;
  qsat_t              sum_sat;
  logic               accept;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // A block size of zero behaves as one, and sizes above the maximum are clipped.
  always_comb begin
    if (blk_dim == '0) begin
      bs = BS_W'(1);
    end else if (int'(blk_dim) > MAX_BLOCK) begin
      bs = BS_W'(MAX_BLOCK);
    end else begin
      bs = BS_W'(blk_dim);
    end
  end

  // The scalar row count is capped at the depth of the store.
  assign n_full = NF_W'(block_rows) * NF_W'(bs);
  assign n_rows = (32'(n_full) > 32'(MAX_ROWS)) ? (ROW_W + 1)'(MAX_ROWS)
                                                : (ROW_W + 1)'(n_full);

  assign idx_full = IDX_W'(brow_q) * IDX_W'(bs) + IDX_W'(irow_q);

  // A loaded element is kept only when it lies on the diagonal inside the matrix.
  assign load_ok = (bcol_q == brow_q) && (irow_q == icol_q)
                && (32'(irow_q) < 32'(bs))
                && (32'(brow_q) < 32'(block_rows))
                && (32'(idx_full) < 32'(n_rows));
  assign row_ok  = 32'(row_q) < 32'(n_rows);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= 32'sd65536;
      beta_gain  <= '0;
      blk_dim    <= 5'd1;
      block_rows <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA:      alpha_gain <= cfg_data;
        REG_BETA:       beta_gain  <= cfg_data;
        REG_BLK_DIM:    blk_dim    <= cfg_data[4:0];
        REG_BLOCK_ROWS: block_rows <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  // The command is captured when it is taken and held until the next one.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      brow_q <= block_row;
      bcol_q <= block_col;
      irow_q <= in_row;
      icol_q <= in_col;
      elem_q <= elem_value;
      row_q  <= row;
      x_q    <= x_value;
      y_q    <= y_value;
    end
  end

  // Store write port: the reset sweep, a diagonal load or a clear.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ROW_W'(row_q);
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
      end
      S_CHECK: begin
        if (op_q == OP_LOAD && load_ok) begin
          wr_en   = 1'b1;
          wr_addr = idx_full[ROW_W-1:0];
          wr_data = elem_q;
        end else if (op_q == OP_CLEAR && row_ok) begin
          wr_en   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      diag_mem[wr_addr] <= wr_data;
    end
    rd_data <= diag_mem[ROW_W'(row_q)];
  end

  // Operand selection for the shared multiplier; product and result are registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = alpha_gain;
        mul_b = in_range ? rd_data : '0;
      end
      S_M1W: begin
        mul_a = beta_gain;
        mul_b = y_q;
      end
      S_M2: begin
        mul_a = mul_q;
        mul_b = x_q;
      end
      default: begin
      end
    endcase
  end

  bdsa_qmul u_qmul (
    .clk   (clk),
    .a     (mul_a),
    .b     (mul_b),
    .q     (mul_q),
    .q_ovf (mul_ovf)
  );

  // In the add state the multiplier holds the full diagonal term.
  assign sum_wide = 64'(t1) + 64'(mul_q);
  assign sum_sat  = sat_q32(sum_wide);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == ROW_W'(MAX_ROWS - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_CHECK;
      S_CHECK: state_next = (op_q == OP_COMPUTE) ? S_M1 : S_IDLE;
      S_M1:    state_next = S_M1W;
      S_M1W:   state_next = S_M2;
      S_M2:    state_next = S_M2W;
      S_M2W:   state_next = S_ADD;
      S_ADD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_ADD);
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Datapath registers; the overflow flag gathers every saturation of the command.
  always_ff @(posedge clk) begin
    case (state)
      S_CHECK: begin
        in_range <= row_ok;
        ovf_acc  <= 1'b0;
      end
      S_M2: begin
        ovf_acc <= ovf_acc | mul_ovf;
      end
      S_M2W: begin
        t1      <= mul_q;
        ovf_acc <= ovf_acc | mul_ovf;
      end
      S_ADD: begin
        y_out    <= sum_sat.val;
        overflow <= ovf_acc | mul_ovf | sum_sat.ovf;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEXT(a_done_only_after_add, clk, rst, state != S_ADD, !done, "result strobe without add step")
  `ASSERT_IMPLIES(a_no_write_when_idle, clk, rst, state == S_IDLE, !wr_en, "store written while idle")
  `ASSERT_IMPLIES(a_compute_latency, clk, rst, accept && opcode == OP_COMPUTE, ##7 done, "compute result missing")
  `ASSERT_IMPLIES(a_no_accept_in_sweep, clk, rst, state == S_CLEAR, !accept, "command taken during sweep")

endmodule

FILE: hdl/bdsa_qmul.sv
// Two-stage Q16.16 multiplier: exact product, then floor shift and saturation.
module bdsa_qmul
  import bdsa_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q,
  output logic               q_ovf
);

  logic signed [63:0] prod;
  logic signed [63:0] shifted;
  qsat_t              clipped;

  // An arithmetic shift drops the low bits, which rounds towards minus infinity.
  assign shifted = prod >>> 16;
  assign clipped = sat_q32(shifted);

  always_ff @(posedge clk) begin
    prod  <= a * b;
    q     <= clipped.val;
    q_ovf <= clipped.ovf;
  end

endmodule

FILE: tb/bsr_diagonal_scale_axpby_tb.sv
// Self-checking testbench for the block-sparse diagonal-scale axpby block.
`timescale 1ns / 1ps

// Commands are driven on the falling edge and taken at the rising edge where start is
// high and busy is low. Each accepted command is run at once through a behavioural
// copy of the block, which keeps its own diagonal store and register values. That copy
// queues the word that a compute command should give. A separate process takes every
// result word at the rising edge that ends its done cycle and compares it with the
// oldest queued word. The receiver cannot hold results off, so only the sender idles.
module bsr_diagonal_scale_axpby_tb
  import bdsa_pkg::*;
;

  // The one opcode that the block ignores has no name in the package.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam longint Q16_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_LO = 64'shFFFF_FFFF_8000_0000;
  localparam logic [31:0] Q16_ONE = 32'h0001_0000;

  // Pause after the last result before the registers may be touched. A load or a
  // clear keeps the block busy and gives no word, so this margin covers a command
  // that is still in flight when the queue runs dry.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         block_row;
    logic [9:0]         block_col;
    logic [3:0]         in_row;
    logic [3:0]         in_col;
    logic signed [31:0] elem_value;
    logic [9:0]         row;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } diag_cmd_t;

  typedef struct packed {
    logic [31:0] y;
    logic        ovf;
  } axpby_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = '0;
  logic [9:0]         block_row = '0;
  logic [9:0]         block_col = '0;
  logic [3:0]         in_row = '0;
  logic [3:0]         in_col = '0;
  logic signed [31:0] elem_value = '0;
  logic [9:0]         row = '0;
  logic signed [31:0] x_value = '0;
  logic signed [31:0] y_value = '0;
  logic               done;
  logic signed [31:0] y_out;
  logic               overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // Mirror of the block's registers, starting from their reset values.
  logic signed [31:0] alpha_cfg = 32'sh0001_0000;
  logic signed [31:0] beta_cfg  = 32'sh0000_0000;
  logic [4:0]         bsize_cfg = 5'd1;
  logic [10:0]        brows_cfg = 11'd0;
  logic signed [31:0] diag_mirror [0:MAX_ROWS-1];

  axpby_word_t expected_axpby [$];
  int          error_count = 0;
  int          sender_idle_pct = 0;

  bsr_diagonal_scale_axpby dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .block_row (block_row),
    .block_col (block_col),
    .in_row    (in_row),
    .in_col    (in_col),
    .elem_value(elem_value),
    .row       (row),
    .x_value   (x_value),
    .y_value   (y_value),
    .done      (done),
    .y_out     (y_out),
    .overflow  (overflow),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioural copy of the block.
  // ---------------------------------------------------------------------------

  function automatic longint clip_q32(input longint v, inout bit clipped);
    if (v > Q16_HI) begin
      clipped = 1'b1;
      return Q16_HI;
    end
    if (v < Q16_LO) begin
      clipped = 1'b1;
      return Q16_LO;
    end
    return v;
  endfunction

  // Exact product, then an arithmetic shift, which drops the low bits towards minus
  // infinity, then clipping. Both operands are already within 32 signed bits.
  function automatic longint q16_mul(input longint a, input longint b, inout bit clipped);
    longint p;
    p = a * b;
    return clip_q32(p >>> 16, clipped);
  endfunction

  // A block size of zero behaves as one, and anything above the maximum as the maximum.
  function automatic int unsigned block_edge();
    if (bsize_cfg == 0) return 1;
    if (bsize_cfg > MAX_BLOCK) return MAX_BLOCK;
    return bsize_cfg;
  endfunction

  function automatic int unsigned scalar_rows();
    int unsigned n;
    n = brows_cfg * block_edge();
    return (n > MAX_ROWS) ? MAX_ROWS : n;
  endfunction

  function automatic void predict_axpby(input diag_cmd_t c);
    int unsigned eb;
    int unsigned n;
    int unsigned idx;
    bit          clipped;
    longint      d;
    longint      t1;
    longint      t2;
    eb = block_edge();
    n  = scalar_rows();
    clipped = 1'b0;
    case (c.opcode)
      OP_LOAD: begin
        // Only an element on the diagonal of a diagonal block is kept.
        if (c.block_col == c.block_row && c.in_row == c.in_col && c.in_row < eb &&
            c.block_row < brows_cfg) begin
          idx = c.block_row * eb + c.in_row;
          if (idx < n) diag_mirror[idx] = c.elem_value;
        end
      end
      OP_CLEAR: begin
        if (c.row < n) diag_mirror[c.row] = '0;
      end
      OP_COMPUTE: begin
        // A row beyond the configured size reads as a zero diagonal.
        d  = (c.row < n) ? longint'(diag_mirror[c.row]) : 64'sd0;
        t2 = q16_mul(longint'(alpha_cfg), d, clipped);
        t2 = q16_mul(t2, longint'(c.x_value), clipped);
        t1 = q16_mul(longint'(beta_cfg), longint'(c.y_value), clipped);
        t1 = clip_q32(t1 + t2, clipped);
        expected_axpby.push_back('{y: t1[31:0], ovf: clipped});
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every done cycle must match the oldest queued word.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    axpby_word_t want;
    if (!rst && done) begin
      if (expected_axpby.size() == 0) begin
        $display("%0t: unexpected result word y_out=%h overflow=%b", $time, y_out, overflow);
        error_count++;
      end else begin
        want = expected_axpby.pop_front();
        if (y_out !== want.y) begin
          $display("%0t: y_out mismatch, expected %h, got %h", $time, want.y, y_out);
          error_count++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow mismatch, expected %b, got %b", $time, want.ovf, overflow);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving tasks.
  // ---------------------------------------------------------------------------

  // Presents one command, after an optional random gap, and holds it until the block
  // takes it. Start is left high so that a following command runs back to back.
  task automatic drive_command(input diag_cmd_t c);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    opcode     <= c.opcode;
    block_row  <= c.block_row;
    block_col  <= c.block_col;
    in_row     <= c.in_row;
    in_col     <= c.in_col;
    elem_value <= c.elem_value;
    row        <= c.row;
    x_value    <= c.x_value;
    y_value    <= c.y_value;
    do @(posedge clk); while (busy);
    predict_axpby(c);
  endtask

  // Lets the block drain: every queued word must arrive, then a short margin passes.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_axpby.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_ALPHA:      alpha_cfg = data;
      REG_BETA:       beta_cfg  = data;
      REG_BLK_DIM:    bsize_cfg = data[4:0];
      REG_BLOCK_ROWS: brows_cfg = data[10:0];
      default: ;
    endcase
  endtask

  // Registers are only rewritten once the block has gone quiet.
  task automatic set_config(input logic [31:0] alpha, input logic [31:0] beta,
                            input logic [31:0] bsize, input logic [31:0] brows);
    settle();
    write_register(REG_ALPHA, alpha);
    write_register(REG_BETA, beta);
    write_register(REG_BLK_DIM, bsize);
    write_register(REG_BLOCK_ROWS, brows);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic diag_cmd_t make_cmd(input logic [1:0] op, input logic [9:0] brow,
                                         input logic [9:0] bcol, input logic [3:0] irow,
                                         input logic [3:0] icol, input logic [31:0] elem,
                                         input logic [9:0] r, input logic [31:0] x,
                                         input logic [31:0] y);
    return '{opcode: op, block_row: brow, block_col: bcol, in_row: irow, in_col: icol,
             elem_value: elem, row: r, x_value: x, y_value: y};
  endfunction

  // Mix of full-range values, small values that keep the arithmetic out of saturation,
  // the corner values, and mid-sized ones that saturate only now and then.
  function automatic logic [31:0] random_q16();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2:    return v;
      3, 4, 5, 6: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      7: begin
        case ($urandom_range(0, 6))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return Q16_ONE;
          4:       return 32'hFFFF_0000;
          5:       return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $signed(v) >>> $urandom_range(4, 14);
    endcase
  endfunction

  // Most commands are well formed against the current size, so that loads really land
  // on the diagonal and computes read what was loaded; the rest are fully random.
  function automatic diag_cmd_t random_command();
    diag_cmd_t   c;
    int unsigned eb;
    int unsigned n;
    int unsigned r;
    int unsigned pick;
    eb = block_edge();
    n  = scalar_rows();
    c.opcode     = 2'($urandom);
    c.block_row  = 10'($urandom);
    c.block_col  = 10'($urandom);
    c.in_row     = 4'($urandom);
    c.in_col     = 4'($urandom);
    c.elem_value = random_q16();
    c.row        = 10'($urandom);
    c.x_value    = random_q16();
    c.y_value    = random_q16();
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c.opcode = OP_LOAD;
      if (n != 0 && $urandom_range(0, 9) != 0) begin
        r = $urandom_range(0, n - 1);
        c.block_row = 10'(r / eb);
        c.block_col = c.block_row;
        c.in_row    = 4'(r % eb);
        c.in_col    = c.in_row;
      end
    end else if (pick < 80) begin
      c.opcode = OP_COMPUTE;
      if (n != 0 && $urandom_range(0, 9) != 0) c.row = 10'($urandom_range(0, n - 1));
    end else if (pick < 88) begin
      c.opcode = OP_CLEAR;
      if (n != 0 && $urandom_range(0, 3) != 0) c.row = 10'($urandom_range(0, n - 1));
    end
    return c;
  endfunction

  function automatic logic [31:0] random_gain();
    if ($urandom_range(0, 3) == 0) return Q16_ONE;
    return random_q16();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // With the reset registers there are no rows at all, so loads and clears fall away
  // and computes see a zero diagonal. Then the whole store is opened up and a few rows
  // are read back before anything is loaded: they must all still be zero.
  task automatic test_reset_state();
    drive_command(make_cmd(OP_LOAD, 0, 0, 0, 0, 32'h0003_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 0, Q16_ONE, 32'h1234_5678));
    drive_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    set_config(Q16_ONE, Q16_ONE, 1, 1024);
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 0, Q16_ONE, 32'h0002_8000));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 511, 32'h7FFF_FFFF, 32'hFFFF_0000));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 1023, 32'h8000_0000, 32'h0000_0001));
  endtask

  // Four-by-four blocks, eight block rows, so 32 scalar rows.
  task automatic test_directed_cases();
    set_config(Q16_ONE, Q16_ONE, 4, 8);
    // A proper diagonal element lands at row 2*4+3 and is read straight back.
    drive_command(make_cmd(OP_LOAD, 2, 2, 3, 3, 32'h0002_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 11, 32'h0001_8000, 32'h0000_4000));
    // Off-diagonal block, off-diagonal element, in_row past the block edge and a block
    // row past the configured count must all leave the store alone.
    drive_command(make_cmd(OP_LOAD, 2, 3, 1, 1, 32'h0005_0000, 0, 0, 0));
    drive_command(make_cmd(OP_LOAD, 2, 2, 1, 2, 32'h0005_0000, 0, 0, 0));
    drive_command(make_cmd(OP_LOAD, 2, 2, 5, 5, 32'h0005_0000, 0, 0, 0));
    drive_command(make_cmd(OP_LOAD, 8, 8, 0, 0, 32'h0005_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 9, Q16_ONE, 0));
    // Largest positive entry and inputs: the product with x and the final add clip.
    drive_command(make_cmd(OP_LOAD, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // Most negative entry at the last row, squared the other way round.
    drive_command(make_cmd(OP_LOAD, 7, 7, 3, 3, 32'h8000_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 31, 32'h8000_0000, 32'h8000_0000));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 31, 32'h0000_0001, 32'hFFFF_FFFF));
    // Rows outside the size read as zero.
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 32, Q16_ONE, 32'h0002_0000));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 1023, Q16_ONE, 32'hFFFE_0000));
    // Clearing inside the size zeroes the entry; outside it is ignored.
    drive_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 11, 0, 0));
    drive_command(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 900, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 11, 32'h0001_8000, 32'h0000_4000));
    // The unused opcode with every field at its top value gives nothing.
    drive_command(make_cmd(OP_UNUSED, 1023, 1023, 15, 15, 32'hFFFF_FFFF, 1023,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drive_command(make_cmd(OP_LOAD, 1023, 1023, 15, 15, 32'hFFFF_FFFF, 1023, 0, 0));
  endtask

  // The gains at their extremes, including the clip of alpha times the diagonal.
  task automatic test_gain_extremes();
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 2, 4);
    drive_command(make_cmd(OP_LOAD, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 0, Q16_ONE, 0));
    drive_command(make_cmd(OP_LOAD, 3, 3, 1, 1, 32'h8000_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 7, 32'h8000_0000, 32'h8000_0000));
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 2, 4);
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 32'h0000_0001, 32'h7FFF_FFFF));
    set_config(32'h0000_0000, 32'h0000_0000, 2, 4);
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 7, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  // Block size zero and sizes past the maximum, and row counts that overrun the store.
  task automatic test_size_extremes();
    // Size zero behaves as one; 1024 block rows cover the whole store.
    set_config(Q16_ONE, 0, 0, 1024);
    drive_command(make_cmd(OP_LOAD, 1023, 1023, 0, 0, 32'h0003_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 1023, Q16_ONE, 0));
    // Size 31 is cut to 16 and 2047 block rows are capped at the store depth: block
    // row 63 still fits, block row 64 runs past the end.
    set_config(Q16_ONE, 0, 31, 2047);
    drive_command(make_cmd(OP_LOAD, 63, 63, 15, 15, 32'hFFFD_0000, 0, 0, 0));
    drive_command(make_cmd(OP_LOAD, 64, 64, 0, 0, 32'h0009_0000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 1023, Q16_ONE, 0));
    // Exactly the maximum edge, a single block row.
    set_config(Q16_ONE, Q16_ONE, 16, 1);
    drive_command(make_cmd(OP_LOAD, 0, 0, 15, 15, 32'h0000_8000, 0, 0, 0));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 15, Q16_ONE, Q16_ONE));
    drive_command(make_cmd(OP_COMPUTE, 0, 0, 0, 0, 0, 16, Q16_ONE, Q16_ONE));
  endtask

  // Several register settings, each with its own sender idling.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(random_gain(), random_gain(), 4, 16);
        1: set_config(random_gain(), random_gain(), 1, 1024);
        2: set_config(random_gain(), random_gain(), 16, 64);
        3: set_config(random_gain(), random_gain(), $urandom_range(0, 31),
                      $urandom_range(0, 2047));
        4: set_config(random_gain(), random_gain(), 3, 5);
        default: set_config(random_gain(), random_gain(), $urandom_range(0, 31),
                            $urandom_range(1, 40));
      endcase
      case (phase % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 53;
        default: sender_idle_pct = 12;
      endcase
      repeat (320) drive_command(random_command());
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < MAX_ROWS; i++) diag_mirror[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_cases();
    test_gain_extremes();
    test_size_extremes();
    test_random_traffic();

    // Drain the last words and allow for any load or clear still in progress.
    settle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The block clears its whole store after reset and then takes one command at a time,
  // so this bound is many times the slowest correct run.
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
